// ----- rtl/assert_macros.svh -----
// assertion macros used by the port-level checker of this block
// no dependencies; every macro takes clock, active-low reset, property parts and a message
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define IPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define IPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ipc_pkg.sv -----
// shared types, constants and codes of the impact pretrigger capture block
// no dependencies; used by ipc_datapath, ipc_ctrl and the top level
package ipc_pkg;

  // sizing
  localparam int HISTORY_DEPTH = 32;
  localparam int PRE_COUNT     = 16;
  localparam int EVENT_LIMIT   = 256;

  localparam int PTR_W  = $clog2(HISTORY_DEPTH);
  localparam int CNT_W  = $clog2(EVENT_LIMIT + 1);
  localparam int SQ_STEPS    = 4;
  localparam int SQRT_STEPS  = 16;
  localparam int STEP_MAX    = (PRE_COUNT > SQRT_STEPS) ? PRE_COUNT : SQRT_STEPS;
  localparam int STEP_W      = $clog2(STEP_MAX + 1);

  // first pretrigger slot, relative to the advanced write pointer
  localparam int RD_OFFSET = (HISTORY_DEPTH * 64 - 1 - PRE_COUNT) % HISTORY_DEPTH;
  // event length right after a trigger
  localparam int FIRST_LEN = (PRE_COUNT + 1 < EVENT_LIMIT) ? PRE_COUNT + 1 : EVENT_LIMIT;

  localparam logic [CNT_W-1:0] LIMIT_C    = CNT_W'(EVENT_LIMIT);
  localparam logic [CNT_W-1:0] LIMIT_M1_C = CNT_W'(EVENT_LIMIT - 1);

  // magnitude scaling
  localparam logic [15:0] ONE_G     = 16'd4096;
  localparam logic [15:0] DEAD_ZONE = 16'd410;

  // port widths
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 104;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_THR = 2'd0,
    REG_END_THR   = 2'd1,
    REG_TAIL      = 2'd2,
    REG_BG_SKIP   = 2'd3
  } cfg_idx_e;

  // axis fed to the squaring multiplier
  typedef enum logic [1:0] {
    AX_X    = 2'd0,
    AX_Y    = 2'd1,
    AX_Z    = 2'd2,
    AX_NONE = 2'd3
  } axis_e;

  // controller states, one-hot
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SQR    = 8'b0000_0010,
    S_ROOT   = 8'b0000_0100,
    S_DECIDE = 8'b0000_1000,
    S_PRE_RD = 8'b0001_0000,
    S_PRE_LD = 8'b0010_0000,
    S_CUR    = 8'b0100_0000,
    S_NUL    = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic        [31:0] time_ms;
    logic signed [15:0] accel_z;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_x;
  } accel_in_t;

  // result payload without the record flag and the last marker
  typedef struct packed {
    logic               background_ready;
    logic        [31:0] duration_ms;
    logic        [8:0]  event_length;
    logic               event_done;
    logic               capturing;
    logic        [7:0]  rec_position;
    logic signed [15:0] rec_z;
    logic signed [15:0] rec_y;
    logic signed [15:0] rec_x;
  } out_t;

  localparam int OUT_PAD_W = OUT_TDATA_W - $bits(out_t);

  // controller to datapath
  typedef struct packed {
    logic  accept;
    logic  mul_step;
    axis_e axis;
    logic  sqrt_step;
    logic  decide;
    logic  rd_pre;
    logic  load_pre;
    logic  load_cur;
    logic  load_null;
    logic  out_last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic trigger;
    logic active;
    logic rec_ok;
    logic pos_final;
    logic out_free;
  } stat_t;

endpackage

// ----- rtl/ipc_datapath.sv -----
// datapath: configuration registers, history ring, magnitude unit, event state, output register
// depends on ipc_pkg
module ipc_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ipc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ipc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  ipc_pkg::accel_in_t               sample_i,
  input  ipc_pkg::cmd_t                    cmd_i,
  output ipc_pkg::stat_t                   stat_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic                             out_user_o,
  output logic                             out_last_o,
  output ipc_pkg::out_t                    out_rec_o
);

  // configuration registers
  logic [14:0] start_thr_q;
  logic [14:0] end_thr_q;
  logic [7:0]  tail_set_q;
  logic [15:0] bg_skip_q;

  // sample and magnitude unit
  ipc_pkg::accel_in_t smp_q;
  logic [31:0] sq_q, sq_d;
  logic [31:0] acc_q, acc_d;
  logic [17:0] rem_q, rem_d;
  logic [15:0] root_q, root_d;

  // history ring and its read port
  logic [47:0]                       ring_mem [ipc_pkg::HISTORY_DEPTH];
  logic [ipc_pkg::HISTORY_DEPTH-1:0] vld_q;
  logic [ipc_pkg::PTR_W-1:0]         wp_q;
  logic [ipc_pkg::PTR_W-1:0]         rd_idx_q, rd_idx_d;
  logic [47:0]                       rd_data_q;
  logic                              rd_vld_q;

  // event state
  logic                      active_q;
  logic                      done_q;
  logic [ipc_pkg::CNT_W-1:0] cnt_q;
  logic [ipc_pkg::CNT_W-1:0] pos_q;
  logic [7:0]                tail_q;
  logic [31:0]               start_time_q;
  logic [31:0]               dur_q;
  logic [15:0]               quiet_q;

  // output register
  logic           out_valid_q;
  logic           out_user_q;
  logic           out_last_q;
  ipc_pkg::out_t  out_rec_q;
  logic           out_free;
  logic           out_load;

  // decision terms
  logic [15:0]               dyn_raw;
  logic [15:0]               dyn;
  logic                      trig;
  logic                      above_end;
  logic                      cap_rec;
  logic [ipc_pkg::CNT_W-1:0] cnt_new;
  logic                      tail_end;
  logic [ipc_pkg::PTR_W:0]   rd_sum;
  logic [ipc_pkg::PTR_W-1:0] rd_start;

  // squarer and root step
  logic signed [15:0] mul_a;
  logic signed [31:0] mul_p;
  logic [19:0]        rem_sh;
  logic [19:0]        trial;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_thr_q <= 15'd8192;
      end_thr_q   <= 15'd2048;
      tail_set_q  <= 8'd10;
      bg_skip_q   <= 16'd10;
    end else if (cfg_we_i) begin
      case (ipc_pkg::cfg_idx_e'(cfg_idx_i))
        ipc_pkg::REG_START_THR: start_thr_q <= cfg_data_i[14:0];
        ipc_pkg::REG_END_THR:   end_thr_q   <= cfg_data_i[14:0];
        ipc_pkg::REG_TAIL:      tail_set_q  <= cfg_data_i[7:0];
        ipc_pkg::REG_BG_SKIP:   bg_skip_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // squaring and digit-by-digit square root
  always_comb begin
    case (cmd_i.axis)
      ipc_pkg::AX_X: mul_a = smp_q.accel_x;
      ipc_pkg::AX_Y: mul_a = smp_q.accel_y;
      ipc_pkg::AX_Z: mul_a = smp_q.accel_z;
      default:       mul_a = '0;
    endcase
    mul_p  = mul_a * mul_a;
    rem_sh = {rem_q, acc_q[31:30]};
    trial  = {2'b00, root_q, 2'b01};

    sq_d   = sq_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (cmd_i.accept) begin
      sq_d   = '0;
      acc_d  = '0;
      rem_d  = '0;
      root_d = '0;
    end else if (cmd_i.mul_step) begin
      sq_d  = unsigned'(mul_p);
      acc_d = acc_q + sq_q;
    end else if (cmd_i.sqrt_step) begin
      acc_d = {acc_q[29:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = 18'(rem_sh - trial);
        root_d = {root_q[14:0], 1'b1};
      end else begin
        rem_d  = rem_sh[17:0];
        root_d = {root_q[14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      smp_q <= sample_i;
    end
    sq_q   <= sq_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  // dynamic acceleration and event decision
  always_comb begin
    dyn_raw   = (root_q >= ipc_pkg::ONE_G) ? root_q - ipc_pkg::ONE_G : ipc_pkg::ONE_G - root_q;
    dyn       = (dyn_raw < ipc_pkg::DEAD_ZONE) ? '0 : dyn_raw;
    trig      = !active_q && (dyn > {1'b0, start_thr_q});
    above_end = dyn > {1'b0, end_thr_q};
    cap_rec   = cnt_q < ipc_pkg::LIMIT_C;
    cnt_new   = cap_rec ? cnt_q + 1'b1 : cnt_q;
    tail_end  = above_end ? (tail_set_q == '0) : (tail_q <= 8'd1);
    rd_sum    = {1'b0, wp_q} + (ipc_pkg::PTR_W + 1)'(ipc_pkg::RD_OFFSET);
    rd_start  = (rd_sum >= (ipc_pkg::PTR_W + 1)'(ipc_pkg::HISTORY_DEPTH)) ?
                ipc_pkg::PTR_W'(rd_sum - (ipc_pkg::PTR_W + 1)'(ipc_pkg::HISTORY_DEPTH)) :
                rd_sum[ipc_pkg::PTR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      done_q       <= 1'b0;
      cnt_q        <= '0;
      pos_q        <= '0;
      tail_q       <= '0;
      start_time_q <= '0;
      dur_q        <= '0;
      quiet_q      <= '0;
    end else if (cmd_i.decide) begin
      done_q <= 1'b0;
      if (trig) begin
        active_q     <= 1'b1;
        cnt_q        <= ipc_pkg::CNT_W'(ipc_pkg::FIRST_LEN);
        pos_q        <= '0;
        tail_q       <= tail_set_q;
        start_time_q <= smp_q.time_ms;
      end else if (active_q) begin
        cnt_q <= cnt_new;
        pos_q <= cnt_q;
        if (above_end) begin
          tail_q <= tail_set_q;
        end else if (tail_q != '0) begin
          tail_q <= tail_q - 1'b1;
        end
        if (tail_end || (cnt_new >= ipc_pkg::LIMIT_C)) begin
          active_q <= 1'b0;
          dur_q    <= smp_q.time_ms - start_time_q;
          done_q   <= 1'b1;
        end
      end else if (quiet_q != '1) begin
        quiet_q <= quiet_q + 1'b1;
      end
    end else if (cmd_i.load_pre || cmd_i.load_cur) begin
      pos_q <= pos_q + 1'b1;
    end
  end

  // history ring write pointer, valid bits and read index
  always_comb begin
    rd_idx_d = rd_idx_q;
    if (cmd_i.decide) begin
      rd_idx_d = rd_start;
    end else if (cmd_i.rd_pre) begin
      rd_idx_d = (rd_idx_q == ipc_pkg::PTR_W'(ipc_pkg::HISTORY_DEPTH - 1)) ? '0 : rd_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      vld_q    <= '0;
      rd_idx_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_idx_q <= rd_idx_d;
      if (cmd_i.accept) begin
        vld_q[wp_q] <= 1'b1;
        wp_q <= (wp_q == ipc_pkg::PTR_W'(ipc_pkg::HISTORY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (cmd_i.rd_pre) begin
        rd_vld_q <= vld_q[rd_idx_q];
      end
    end
  end

  // ring storage, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ring_mem[wp_q] <= {sample_i.accel_z, sample_i.accel_y, sample_i.accel_x};
    end
    if (cmd_i.rd_pre) begin
      rd_data_q <= ring_mem[rd_idx_q];
    end
  end

  // output register
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = cmd_i.load_pre || cmd_i.load_cur || cmd_i.load_null;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_user_q                 <= !cmd_i.load_null;
      out_last_q                 <= cmd_i.out_last;
      out_rec_q.capturing        <= active_q;
      out_rec_q.event_done       <= done_q;
      out_rec_q.event_length     <= 9'(cnt_q);
      out_rec_q.duration_ms      <= dur_q;
      out_rec_q.background_ready <= quiet_q >= bg_skip_q;
      out_rec_q.rec_position     <= cmd_i.load_null ? '0 : 8'(pos_q);
      if (cmd_i.load_pre) begin
        {out_rec_q.rec_z, out_rec_q.rec_y, out_rec_q.rec_x} <= rd_vld_q ? rd_data_q : '0;
      end else if (cmd_i.load_cur) begin
        out_rec_q.rec_x <= smp_q.accel_x;
        out_rec_q.rec_y <= smp_q.accel_y;
        out_rec_q.rec_z <= smp_q.accel_z;
      end else begin
        out_rec_q.rec_x <= '0;
        out_rec_q.rec_y <= '0;
        out_rec_q.rec_z <= '0;
      end
    end
  end

  // status to the controller
  assign stat_o.trigger   = trig;
  assign stat_o.active    = active_q;
  assign stat_o.rec_ok    = pos_q < ipc_pkg::LIMIT_C;
  assign stat_o.pos_final = pos_q == ipc_pkg::LIMIT_M1_C;
  assign stat_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign out_user_o  = out_user_q;
  assign out_last_o  = out_last_q;
  assign out_rec_o   = out_rec_q;

endmodule

// ----- rtl/ipc_ctrl.sv -----
// controller: sequences squaring, square root, event decision and record readout
// depends on ipc_pkg
module ipc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ipc_pkg::stat_t stat_i,
  output ipc_pkg::cmd_t  cmd_o
);

  localparam logic [ipc_pkg::STEP_W-1:0] STEP_ONE = ipc_pkg::STEP_W'(1);
  localparam logic [ipc_pkg::STEP_W-1:0] STEP_SQ  = ipc_pkg::STEP_W'(ipc_pkg::SQ_STEPS);

  ipc_pkg::state_e            state_q, state_d;
  logic [ipc_pkg::STEP_W-1:0] step_q, step_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    cmd_o.axis = ipc_pkg::AX_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ipc_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          step_d       = STEP_SQ;
          state_d      = ipc_pkg::S_SQR;
        end
      end
      ipc_pkg::S_SQR: begin
        cmd_o.mul_step = 1'b1;
        if (step_q == STEP_SQ) begin
          cmd_o.axis = ipc_pkg::AX_X;
        end else if (step_q == STEP_SQ - 1'b1) begin
          cmd_o.axis = ipc_pkg::AX_Y;
        end else if (step_q == STEP_SQ - 2'd2) begin
          cmd_o.axis = ipc_pkg::AX_Z;
        end
        step_d = step_q - 1'b1;
        if (step_q == STEP_ONE) begin
          step_d  = ipc_pkg::STEP_W'(ipc_pkg::SQRT_STEPS);
          state_d = ipc_pkg::S_ROOT;
        end
      end
      ipc_pkg::S_ROOT: begin
        cmd_o.sqrt_step = 1'b1;
        step_d = step_q - 1'b1;
        if (step_q == STEP_ONE) begin
          state_d = ipc_pkg::S_DECIDE;
        end
      end
      ipc_pkg::S_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (stat_i.trigger) begin
          step_d  = ipc_pkg::STEP_W'(ipc_pkg::PRE_COUNT);
          state_d = ipc_pkg::S_PRE_RD;
        end else if (stat_i.active) begin
          state_d = ipc_pkg::S_CUR;
        end else begin
          state_d = ipc_pkg::S_NUL;
        end
      end
      ipc_pkg::S_PRE_RD: begin
        cmd_o.rd_pre = 1'b1;
        state_d      = ipc_pkg::S_PRE_LD;
      end
      ipc_pkg::S_PRE_LD: begin
        if (stat_i.out_free) begin
          cmd_o.load_pre = 1'b1;
          cmd_o.out_last = stat_i.pos_final;
          step_d         = step_q - 1'b1;
          if (stat_i.pos_final) begin
            state_d = ipc_pkg::S_IDLE;
          end else if (step_q == STEP_ONE) begin
            state_d = ipc_pkg::S_CUR;
          end else begin
            state_d = ipc_pkg::S_PRE_RD;
          end
        end
      end
      ipc_pkg::S_CUR: begin
        if (stat_i.out_free) begin
          cmd_o.load_cur  = stat_i.rec_ok;
          cmd_o.load_null = !stat_i.rec_ok;
          cmd_o.out_last  = 1'b1;
          state_d         = ipc_pkg::S_IDLE;
        end
      end
      ipc_pkg::S_NUL: begin
        if (stat_i.out_free) begin
          cmd_o.load_null = 1'b1;
          cmd_o.out_last  = 1'b1;
          state_d         = ipc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ipc_pkg::S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ipc_pkg::S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

// ----- rtl/impact_pretrigger_capture.sv -----
// impact pretrigger capture top level; depends on ipc_pkg, ipc_ctrl, ipc_datapath
// from sample accept to its first result: 4 squaring steps, 16 root steps, a decision and a load
// a sample holds the block until its results are loaded; a trigger adds a ring read and a
//   load per pretrigger record, set by the single registered read port of the history ring
// reset: asynchronous, active low; history reads as zeros, event state clears, registers
//   return to their defaults, no clearing pass
module impact_pretrigger_capture (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ipc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ipc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // accel_x, accel_y, accel_z, time_ms
  input  logic [ipc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // rec_x, rec_y, rec_z, rec_position, capturing, event_done, event_length,
  // duration_ms, background_ready, zero fill
  output logic [ipc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // rec_valid
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast
);

  ipc_pkg::accel_in_t sample;
  ipc_pkg::cmd_t      cmd;
  ipc_pkg::stat_t     stat;
  ipc_pkg::out_t      out_rec;

  // input unpacking
  assign sample.accel_x = s_axis_tdata[15:0];
  assign sample.accel_y = s_axis_tdata[31:16];
  assign sample.accel_z = s_axis_tdata[47:32];
  assign sample.time_ms = s_axis_tdata[79:48];

  ipc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ipc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (sample),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast),
    .out_rec_o   (out_rec)
  );

  // output packing
  assign m_axis_tdata = {{ipc_pkg::OUT_PAD_W{1'b0}}, out_rec};

endmodule

// ----- rtl/ipc_checker.sv -----
// port-level checks of the impact pretrigger capture block, bound to its top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module ipc_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata,
  input logic         m_axis_tuser,
  input logic         m_axis_tlast
);

  // a stalled result transaction holds its payload
  `IPC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")

  // a status-only result is the sole result of its sample and carries no record
  `IPC_ASSERT_IMP(a_null_rec, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tlast && (m_axis_tdata[55:0] == 56'd0), "status result with record data")

  // an ending event is no longer capturing
  `IPC_ASSERT_IMP(a_done_idle, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[57], !m_axis_tdata[56], "event done while still capturing")

  // a sample occupies the block, so ready drops after a sample transaction
  `IPC_ASSERT_NXT(a_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready right after a sample transaction")

endmodule

bind impact_pretrigger_capture ipc_checker u_ipc_checker (.*);

// ----- tb/sv/impact_pretrigger_capture_checker.sv -----
// checker for the impact pretrigger capture block: watches the register port and both streams
// depends on ipc_pkg; predicts every result of each sample and compares it in order
module impact_pretrigger_capture_checker
  import ipc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  // accel_x, accel_y, accel_z, time_ms
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  // rec_x, rec_y, rec_z, rec_position, capturing, event_done, event_length,
  // duration_ms, background_ready, zero fill
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,
  // rec_valid
  input  logic                   m_tuser_i,
  input  logic                   m_tlast_i,
  output int                     errors_o,
  output int                     pending_o
);

  typedef struct packed {
    logic rec_valid;
    logic last;
    out_t body;
  } capture_result_t;

  // shadow of the block state and registers
  logic [47:0]      history [HISTORY_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic             capture_on;
  logic [CNT_W-1:0] rec_count;
  logic [7:0]       tail_left;
  logic [31:0]      start_ms;
  logic [31:0]      last_dur;
  logic [15:0]      quiet_run;
  logic [14:0]      start_thr;
  logic [14:0]      end_thr;
  logic [7:0]       tail_len;
  logic [15:0]      bg_skip;

  capture_result_t  expected_records [$];
  int               err_count;

  function automatic logic [31:0] square_axis(input logic signed [15:0] a);
    logic signed [31:0] w;
    w = a;
    return w * w;
  endfunction

  function automatic capture_result_t make_record(input logic [47:0] xyz, input logic [7:0] pos);
    capture_result_t r;
    r = '0;
    r.rec_valid = 1'b1;
    r.body.rec_x = xyz[15:0];
    r.body.rec_y = xyz[31:16];
    r.body.rec_z = xyz[47:32];
    r.body.rec_position = pos;
    return r;
  endfunction

  // works out every result one sample causes and queues them
  task automatic predict_capture(input accel_in_t smp);
    logic [31:0]      sq_sum;
    logic [15:0]      root;
    logic [31:0]      dyn;
    logic [PTR_W-1:0] slot;
    logic             ends;
    logic             done;
    capture_result_t  batch [$];
    capture_result_t  r;
    sq_sum = square_axis(smp.accel_x) + square_axis(smp.accel_y) + square_axis(smp.accel_z);
    // floor square root, one result bit at a time
    root = '0;
    for (int b = 15; b >= 0; b--) begin
      root[b] = 1'b1;
      if (32'(root) * 32'(root) > sq_sum) root[b] = 1'b0;
    end
    dyn = (root >= ONE_G) ? 32'(root - ONE_G) : 32'(ONE_G - root);
    if (dyn < 32'(DEAD_ZONE)) dyn = '0;

    history[wr_ptr] = {smp.accel_z, smp.accel_y, smp.accel_x};
    wr_ptr = wr_ptr + 1'b1;
    done = 1'b0;
    ends = 1'b0;

    if (!capture_on && dyn > 32'(start_thr)) begin
      // trigger: older history first, then the sample itself
      capture_on = 1'b1;
      rec_count = '0;
      tail_left = tail_len;
      start_ms = smp.time_ms;
      for (int k = PRE_COUNT; k > 0; k--) begin
        if (rec_count >= LIMIT_C) break;
        slot = wr_ptr - PTR_W'(1) - PTR_W'(k);
        batch.push_back(make_record(history[slot], rec_count[7:0]));
        rec_count++;
      end
      if (rec_count < LIMIT_C) begin
        batch.push_back(make_record(history[wr_ptr - 1'b1], rec_count[7:0]));
        rec_count++;
      end
    end else if (capture_on) begin
      if (rec_count < LIMIT_C) begin
        batch.push_back(make_record(history[wr_ptr - 1'b1], rec_count[7:0]));
        rec_count++;
      end
      // strong sample reloads the tail, weak one counts it down
      if (dyn > 32'(end_thr)) begin
        tail_left = tail_len;
        ends = (tail_len == 8'd0);
      end else begin
        ends = (tail_left <= 8'd1);
        if (tail_left != 8'd0) tail_left--;
      end
      if (ends || rec_count >= LIMIT_C) begin
        capture_on = 1'b0;
        last_dur = smp.time_ms - start_ms;
        done = 1'b1;
      end
    end else if (quiet_run != 16'hFFFF) begin
      quiet_run++;
    end

    // status only when no record comes out
    if (batch.size() == 0) batch.push_back('0);
    foreach (batch[i]) begin
      r = batch[i];
      r.last = (i == batch.size() - 1);
      r.body.capturing = capture_on;
      r.body.event_done = done;
      r.body.event_length = rec_count;
      r.body.duration_ms = last_dur;
      r.body.background_ready = (quiet_run >= bg_skip);
      expected_records.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t  %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // compares one result transaction with the oldest expectation
  task automatic compare_result();
    capture_result_t want;
    out_t            got;
    got = out_t'(m_tdata_i[$bits(out_t)-1:0]);
    if (expected_records.size() == 0) begin
      err_count++;
      $display("%0t  result with nothing expected: expected none, actual %h", $time, m_tdata_i);
    end else begin
      want = expected_records.pop_front();
      check_field("rec_valid", want.rec_valid, m_tuser_i);
      check_field("last", want.last, m_tlast_i);
      check_field("rec_x", want.body.rec_x, got.rec_x);
      check_field("rec_y", want.body.rec_y, got.rec_y);
      check_field("rec_z", want.body.rec_z, got.rec_z);
      check_field("rec_position", want.body.rec_position, got.rec_position);
      check_field("capturing", want.body.capturing, got.capturing);
      check_field("event_done", want.body.event_done, got.event_done);
      check_field("event_length", want.body.event_length, got.event_length);
      check_field("duration_ms", want.body.duration_ms, got.duration_ms);
      check_field("background_ready", want.body.background_ready, got.background_ready);
      check_field("zero fill", '0, 32'(m_tdata_i[OUT_TDATA_W-1:$bits(out_t)]));
    end
  endtask

  // register writes, sample transactions, result transactions
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (history[i]) history[i] = '0;
      wr_ptr = '0;
      capture_on = 1'b0;
      rec_count = '0;
      tail_left = '0;
      start_ms = '0;
      last_dur = '0;
      quiet_run = '0;
      start_thr = 15'd8192;
      end_thr = 15'd2048;
      tail_len = 8'd10;
      bg_skip = 16'd10;
      expected_records.delete();
      err_count = 0;
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          REG_START_THR: start_thr = cfg_data_i[14:0];
          REG_END_THR:   end_thr = cfg_data_i[14:0];
          REG_TAIL:      tail_len = cfg_data_i[7:0];
          REG_BG_SKIP:   bg_skip = cfg_data_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) predict_capture(accel_in_t'(s_tdata_i));
      if (m_tvalid_i && m_tready_i) compare_result();
      errors_o <= err_count;
      pending_o <= expected_records.size();
    end
  end

endmodule

// ----- tb/sv/impact_pretrigger_capture_test.sv -----
// top of the impact pretrigger capture testbench: clock, reset, register writes and stimulus
// depends on ipc_pkg, impact_pretrigger_capture and impact_pretrigger_capture_checker
module impact_pretrigger_capture_test;
  import ipc_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  typedef enum int {
    RX_FLOW,
    RX_COIN,
    RX_BURSTY
  } rx_mode_e;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;

  int          errors;
  int          pending;
  int          idle_cycles = 0;
  int          burst_left = 1;
  logic [31:0] stamp = '0;
  rx_mode_e    rx_mode = RX_FLOW;
  int          rx_phase_left = 0;
  int          rx_run_left = 0;

  impact_pretrigger_capture dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  impact_pretrigger_capture_checker checker_i (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .m_tuser_i  (m_axis_tuser),
    .m_tlast_i  (m_axis_tlast),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side backpressure, switching at random between free flow, coin tosses and bursts
  always @(posedge clk) begin
    if (rx_phase_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_phase_left = $urandom_range(50, 300);
    end else begin
      rx_phase_left--;
    end
    case (rx_mode)
      RX_FLOW: m_axis_tready <= 1'b1;
      RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
      default: begin
        if (rx_run_left == 0) begin
          m_axis_tready <= ~m_axis_tready;
          rx_run_left = m_axis_tready ? $urandom_range(1, 30) : $urandom_range(1, 6);
        end else begin
          rx_run_left--;
        end
      end
    endcase
  end

  // no transaction on either stream for too long ends the run
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("impact_pretrigger_capture_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic accel_in_t raw_sample(input logic [15:0] x, input logic [15:0] y,
                                           input logic [15:0] z);
    return {stamp, z, y, x};
  endfunction

  // mostly along one axis with a little noise on the others
  function automatic accel_in_t aimed_sample(input int mag);
    accel_in_t smp;
    int        lead;
    lead = $urandom_range(0, 1) ? mag : -mag;
    smp.accel_x = 16'(int'($urandom_range(0, 300)) - 150);
    smp.accel_y = 16'(int'($urandom_range(0, 300)) - 150);
    smp.accel_z = 16'(int'($urandom_range(0, 300)) - 150);
    case ($urandom_range(0, 2))
      0:       smp.accel_x = 16'(lead);
      1:       smp.accel_y = 16'(lead);
      default: smp.accel_z = 16'(lead);
    endcase
    smp.time_ms = stamp;
    return smp;
  endfunction

  // one sample transaction, then maybe a gap between bursts
  task automatic push_sample(input accel_in_t smp);
    s_axis_tdata <= smp;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    stamp = ($urandom_range(0, 15) == 0) ? $urandom() : stamp + $urandom_range(1, 20);
    burst_left--;
    if (burst_left <= 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  // hold samples back until every expected result is out, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] thr_start, input logic [15:0] thr_end,
                            input logic [15:0] tail_len, input logic [15:0] bg_skip);
    cfg_we <= 1'b1;
    cfg_idx <= REG_START_THR;
    cfg_data <= thr_start;
    @(posedge clk);
    cfg_idx <= REG_END_THR;
    cfg_data <= thr_end;
    @(posedge clk);
    cfg_idx <= REG_TAIL;
    cfg_data <= tail_len;
    @(posedge clk);
    cfg_idx <= REG_BG_SKIP;
    cfg_data <= bg_skip;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // quiet stretches, impacts and decaying tails, with some raw noise; exactly count samples
  task automatic run_random(input int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        push_sample(raw_sample(16'($urandom()), 16'($urandom()), 16'($urandom())));
        sent++;
      end else begin
        repeat ($urandom_range(0, 6)) begin
          if (sent < count) begin
            push_sample(aimed_sample(4096 + int'($urandom_range(0, 800)) - 400));
            sent++;
          end
        end
        repeat ($urandom_range(1, 2)) begin
          if (sent < count) begin
            push_sample(aimed_sample($urandom_range(8000, 32767)));
            sent++;
          end
        end
        repeat ($urandom_range(0, 14)) begin
          if (sent < count) begin
            push_sample(aimed_sample(4096 + ($urandom_range(0, 1) ? 1 : -1) *
                                     int'($urandom_range(0, 4000))));
            sent++;
          end
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // trigger on an empty history, extreme axes, dead zone edge, short tail, readiness
    set_config(16'd8192, 16'd2048, 16'd2, 16'd3);
    stamp = 32'hFFFF_FFFC;
    push_sample(raw_sample(16'h0000, 16'h0000, 16'h8000));
    push_sample(raw_sample(16'h7FFF, 16'h7FFF, 16'h7FFF));
    push_sample(raw_sample(16'h8000, 16'h8000, 16'h8000));
    push_sample(raw_sample(16'd4505, 16'h0000, 16'h0000));
    push_sample(raw_sample(16'h0000, 16'd4506, 16'h0000));
    repeat (3) push_sample(raw_sample(16'h0000, 16'h0000, 16'd4096));
    push_sample(raw_sample(16'h0000, 16'h0000, 16'h0000));
    drain();

    // zero start threshold, zero tail and masked register data
    set_config(16'd0, 16'hFFFF, 16'hFF00, 16'd0);
    push_sample(raw_sample(16'h0000, 16'h0000, 16'd4506));
    push_sample(raw_sample(16'h0000, 16'h0000, 16'd4096));
    push_sample(raw_sample(16'h0000, 16'h0000, 16'd4096));
    push_sample(raw_sample(16'd4505, 16'h0000, 16'h0000));
    drain();

    // top start threshold and tail, zero end threshold; the event then runs into the record limit
    set_config(16'hFFFF, 16'd0, 16'd255, 16'hFFFF);
    push_sample(raw_sample(16'h8000, 16'h8000, 16'h8000));
    push_sample(raw_sample(16'h7FFF, 16'h8000, 16'h7FFF));
    push_sample(raw_sample(16'h0000, 16'h0000, 16'd4096));
    run_random(240);
    drain();

    // random settings
    repeat (3) begin
      set_config(($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(2000, 12000)),
                 16'($urandom_range(0, 5000)), 16'($urandom_range(0, 12)),
                 16'($urandom_range(0, 40)));
      run_random(5);
      drain();
    end

    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("impact_pretrigger_capture_test passed");
    end else begin
      $display("impact_pretrigger_capture_test failed");
    end
    $finish;
  end

endmodule

// ----- impact_pretrigger_capture.f -----
+incdir+rtl
rtl/ipc_pkg.sv
rtl/ipc_datapath.sv
rtl/ipc_ctrl.sv
rtl/impact_pretrigger_capture.sv
rtl/ipc_checker.sv
tb/sv/impact_pretrigger_capture_checker.sv
tb/sv/impact_pretrigger_capture_test.sv
